// ----- rtl/qdip_pkg.sv -----
// Shared types and character constants for the quoted dotted IP parser.
package qdip_pkg;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam logic [1:0] LAST_OCTET = 2'd3;

	typedef enum logic [1:0] {
		PH_FINISHED,
		PH_SEARCH,
		PH_SKIP,
		PH_PARSE
	} phase_t;

	typedef enum logic [1:0] {
		ST_FIRST,
		ST_SECOND,
		ST_THIRD,
		ST_TRAIL
	} step_t;

	// classified text byte as queued between front and back
	typedef struct packed {
		logic       start;
		logic       quote;
		logic       mark;
		logic [7:0] digit;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- rtl/qdip_front.sv -----
// Front end: accepts text bytes, classifies them and feeds the queue.
module qdip_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_of_text,
	input  logic [7:0]         text_byte,
	input  qdip_pkg::q_status_t q_stat,
	output logic               q_push,
	output qdip_pkg::item_t    q_item
);
	import qdip_pkg::*;

	logic  vld_s1;
	item_t item_s1;
	logic  accept;

	assign in_stall = vld_s1 & q_stat.full;
	assign accept   = in_valid & ~in_stall;
	assign q_push   = vld_s1 & ~q_stat.full;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept | in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.start <= start_of_text;
			item_s1.quote <= (text_byte == CH_QUOTE);
			item_s1.mark  <= (text_byte == CH_QUOTE) || (text_byte == CH_DOT);
			item_s1.digit <= text_byte - CH_ZERO;
		end
	end

endmodule

// ----- rtl/qdip_fifo.sv -----
// Short queue of classified items between front and back.
module qdip_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qdip_pkg::item_t     push_item,
	input  logic                pop,
	output qdip_pkg::item_t     pop_item,
	output qdip_pkg::q_status_t stat
);
	import qdip_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/qdip_back.sv -----
// Back end: quote search, octet parsing and the result register.
module qdip_back #(
	parameter int SEARCH_WINDOW = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qdip_pkg::q_status_t q_stat,
	input  qdip_pkg::item_t     q_item,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          first_octet,
	output logic [7:0]          second_octet,
	output logic [7:0]          third_octet,
	output logic [7:0]          fourth_octet
);
	import qdip_pkg::*;

	localparam logic [4:0] WIN = 5'(SEARCH_WINDOW);

	phase_t     phase_q, phase_d;
	step_t      step_q, step_d;
	logic [4:0] pos_q, pos_d, pos_inc;
	logic [1:0] oi_q, oi_d, hold_idx;
	logic [7:0] acc_q, acc_d, mac, fin_val;
	logic       fin, emit, hold_we;
	logic [7:0] held_q [3];
	logic       out_valid_q;
	logic [7:0] oct0_q, oct1_q, oct2_q, oct3_q;

	assign q_pop = ~q_stat.empty & (~out_valid_q | ~out_stall);

	always_comb begin
		phase_d  = phase_q;
		step_d   = step_q;
		pos_d    = pos_q;
		oi_d     = oi_q;
		acc_d    = acc_q;
		pos_inc  = '0;
		mac      = '0;
		fin      = 1'b0;
		fin_val  = acc_q;
		emit     = 1'b0;
		hold_we  = 1'b0;
		hold_idx = oi_q;
		if (q_pop) begin
			if (q_item.start) begin
				phase_d = PH_SEARCH;
				step_d  = ST_FIRST;
				pos_d   = '0;
				oi_d    = '0;
				acc_d   = '0;
			end
			mac = {acc_d[4:0], 3'b000} + {acc_d[6:0], 1'b0} + q_item.digit;
			unique case (phase_d)
				PH_SEARCH: begin
					if (q_item.quote) begin
						phase_d = PH_PARSE;
					end else begin
						pos_inc = pos_d + 5'd1;
						pos_d   = pos_inc;
						if (pos_inc >= WIN) begin
							phase_d = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					phase_d = PH_PARSE;
				end
				PH_PARSE: begin
					unique case (step_d)
						ST_FIRST: begin
							acc_d  = q_item.digit;
							step_d = ST_SECOND;
						end
						ST_SECOND: begin
							if (q_item.mark) begin
								fin     = 1'b1;
								fin_val = acc_d;
							end else begin
								acc_d  = mac;
								step_d = ST_THIRD;
							end
						end
						ST_THIRD: begin
							if (q_item.mark) begin
								fin     = 1'b1;
								fin_val = acc_d;
							end else if (oi_d == LAST_OCTET) begin
								fin     = 1'b1;
								fin_val = mac;
							end else begin
								acc_d  = mac;
								step_d = ST_TRAIL;
							end
						end
						ST_TRAIL: begin
							fin     = 1'b1;
							fin_val = acc_d;
						end
						default: ;
					endcase
				end
				PH_FINISHED: ;
				default: ;
			endcase
			if (fin) begin
				hold_idx = oi_d;
				if (oi_d == LAST_OCTET) begin
					emit    = 1'b1;
					phase_d = PH_FINISHED;
					oi_d    = '0;
				end else begin
					hold_we = 1'b1;
					oi_d    = oi_d + 2'd1;
				end
				step_d = ST_FIRST;
				acc_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FINISHED;
			step_q      <= ST_FIRST;
			pos_q       <= '0;
			oi_q        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			step_q  <= step_d;
			pos_q   <= pos_d;
			oi_q    <= oi_d;
			acc_q   <= acc_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_we) begin
			held_q[hold_idx] <= fin_val;
		end
		if (emit) begin
			oct0_q <= held_q[0];
			oct1_q <= held_q[1];
			oct2_q <= held_q[2];
			oct3_q <= fin_val;
		end
	end

	assign out_valid    = out_valid_q;
	assign first_octet  = oct0_q;
	assign second_octet = oct1_q;
	assign third_octet  = oct2_q;
	assign fourth_octet = oct3_q;

endmodule

// ----- rtl/quoted_dotted_ip_parser_core.sv -----
// Top level of the quoted dotted-decimal IPv4 address parser.
// Throughput: one text byte per cycle while in_stall is low; the parse state updates once per byte.
// Result path: once the byte that completes the fourth octet is accepted, it
// passes the front register, then the queue, then the result register.
// The QUEUE_DEPTH-entry queue lets the input keep flowing while a result stalls.
// Reset: asynchronous, active low; parser waits for a start byte, queue empty.
module quoted_dotted_ip_parser_core #(
	parameter int SEARCH_WINDOW = 18,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       start_of_text,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] first_octet,
	output logic [7:0] second_octet,
	output logic [7:0] third_octet,
	output logic [7:0] fourth_octet
);
	import qdip_pkg::*;

	q_status_t q_stat;
	item_t     push_item;
	item_t     pop_item;
	logic      q_push;
	logic      q_pop;

	qdip_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_of_text (start_of_text),
		.text_byte     (text_byte),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	qdip_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	qdip_back #(
		.SEARCH_WINDOW (SEARCH_WINDOW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_octet  (first_octet),
		.second_octet (second_octet),
		.third_octet  (third_octet),
		.fourth_octet (fourth_octet)
	);

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue pushed while full");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> q_push || in_stall)
		else $error("stalled front item dropped");

	a_pop_frees_output: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && out_valid |-> !out_stall)
		else $error("item consumed while result register blocked");

endmodule
